@@ sv/tcw_pkg.sv @@
`timescale 1ns / 1ps

package tcw_pkg;

   typedef enum logic [1:0] {
      PH_SLOW    = 2'd0,
      PH_AVOID   = 2'd1,
      PH_RECOVER = 2'd2
   } phase_type;

   localparam logic [1:0] MODE_SEND = 2'd0;
   localparam logic [1:0] MODE_ACK  = 2'd1;
   localparam logic [1:0] MODE_LOSS = 2'd2;

   localparam logic [1:0] CSR_INITIAL_WINDOW    = 2'd0;
   localparam logic [1:0] CSR_INITIAL_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_VARIANT           = 2'd2;

   localparam logic [15:0] RESET_WINDOW    = 16'd1;
   localparam logic [15:0] RESET_THRESHOLD = 16'd10000;
   localparam logic [5:0]  NO_LEVEL        = 6'd63;

   typedef struct packed {
      logic        enable;
      logic [1:0]  index;
      logic [15:0] data;
   } csr_write_type;

   // Floor log2; zero gives zero
   function automatic logic [5:0] floor_log2(input logic [31:0] value);
      logic [5:0] level;
      level = 6'd0;
      for (int i = 1; i < 32; i++) begin
         if (value[i]) begin
            level = 6'(i);
         end
      end
      return level;
   endfunction

endpackage

@@ sv/tcw_engine.sv @@
`timescale 1ns / 1ps

module tcw_engine #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tcw_pkg::csr_write_type   csr,
   input  logic                     step,
   input  logic [1:0]               mode,
   input  logic [COUNT_WIDTH-1:0]   packet_number,
   output logic [COUNT_WIDTH-1:0]   window_end_in,
   output logic [COUNT_WIDTH-1:0]   window_size_in,
   output logic [COUNT_WIDTH-1:0]   threshold_in,
   output tcw_pkg::phase_type       phase_in
);
   import tcw_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   logic [15:0]            init_window_ff;
   logic                   variant_ff;
   logic [COUNT_WIDTH-1:0] cwnd_ff, cwnd_in;
   logic [COUNT_WIDTH-1:0] ssthresh_ff, ssthresh_in;
   logic [COUNT_WIDTH-1:0] start_ff, start_in;
   logic [COUNT_WIDTH-1:0] end_ff, end_in;
   phase_type              phase_ff, phase_next;
   logic [5:0]             level_ff, level_in;

   logic [COUNT_WIDTH:0]   inflight;
   logic                   send_ok;
   logic [COUNT_WIDTH-1:0] doubled;
   logic [5:0]             loss_level;

   // Signed in-flight count: an end below the start always allows a send
   assign inflight = {1'b0, end_ff} - {1'b0, start_ff};
   assign send_ok  = inflight[COUNT_WIDTH] || (inflight[COUNT_WIDTH-1:0] < cwnd_ff);
   assign doubled  = cwnd_ff[COUNT_WIDTH-1] ? CNT_MAX : {cwnd_ff[COUNT_WIDTH-2:0], 1'b0};
   assign loss_level = floor_log2(32'(packet_number));

   always_comb begin
      cwnd_in     = cwnd_ff;
      ssthresh_in = ssthresh_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      phase_next  = phase_ff;
      level_in    = level_ff;
      case (mode)
         MODE_SEND: begin
            if (send_ok && end_ff != CNT_MAX) begin
               end_in = end_ff + 1'b1;
            end
         end
         MODE_ACK: begin
            if (packet_number > start_ff) begin
               start_in = packet_number;
               if (phase_ff == PH_AVOID) begin
                  if (cwnd_ff != CNT_MAX) begin
                     cwnd_in = cwnd_ff + 1'b1;
                  end
               end else if (phase_ff == PH_SLOW) begin
                  cwnd_in = doubled;
                  if (doubled >= ssthresh_ff) begin
                     cwnd_in    = ssthresh_ff;
                     phase_next = PH_AVOID;
                  end
               end
            end else begin
               // Stale ack: treat as timeout and restart slow start
               if (end_ff != '0) begin
                  end_in = end_ff - 1'b1;
               end
               ssthresh_in = cwnd_ff >> 1;
               cwnd_in     = COUNT_WIDTH'(init_window_ff);
               phase_next  = PH_SLOW;
            end
         end
         MODE_LOSS: begin
            phase_next = PH_RECOVER;
            if (!(variant_ff && loss_level == level_ff)) begin
               level_in    = loss_level;
               ssthresh_in = cwnd_ff >> 1;
               cwnd_in     = cwnd_ff >> 1;
               phase_next  = PH_AVOID;
            end
         end
         default: begin
         end
      endcase
   end

   assign window_end_in  = end_in;
   assign window_size_in = cwnd_in;
   assign threshold_in   = ssthresh_in;
   assign phase_in       = phase_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_window_ff    <= RESET_WINDOW;
         variant_ff        <= 1'b0;
         cwnd_ff           <= COUNT_WIDTH'(RESET_WINDOW);
         ssthresh_ff       <= COUNT_WIDTH'(RESET_THRESHOLD);
         start_ff          <= '0;
         end_ff            <= '0;
         phase_ff          <= PH_SLOW;
         level_ff          <= NO_LEVEL;
      end else begin
         if (step) begin
            cwnd_ff     <= cwnd_in;
            ssthresh_ff <= ssthresh_in;
            start_ff    <= start_in;
            end_ff      <= end_in;
            phase_ff    <= phase_next;
            level_ff    <= level_in;
         end
         // Writing a start value also loads the live counter
         if (csr.enable) begin
            case (csr.index)
               CSR_INITIAL_WINDOW: begin
                  init_window_ff <= csr.data;
                  cwnd_ff        <= COUNT_WIDTH'(csr.data);
               end
               CSR_INITIAL_THRESHOLD: begin
                  ssthresh_ff <= COUNT_WIDTH'(csr.data);
               end
               CSR_VARIANT: begin
                  variant_ff <= csr.data[0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   a_reset_state: assert property (@(posedge clock)
      reset |=> (phase_ff == PH_SLOW && level_ff == NO_LEVEL && end_ff == '0))
      else $error("engine state not cleared by reset");

   a_send_keeps_window: assert property (@(posedge clock) disable iff (reset)
      (step && mode == MODE_SEND && !csr.enable) |=>
         ($stable(cwnd_ff) && $stable(ssthresh_ff) && $stable(phase_ff)))
      else $error("send event changed window or phase");

   a_loss_phase: assert property (@(posedge clock) disable iff (reset)
      (step && mode == MODE_LOSS) |=> (phase_ff == PH_AVOID || phase_ff == PH_RECOVER))
      else $error("loss event left wrong phase");

endmodule

@@ sv/tcp_congestion_window_top.sv @@
`timescale 1ns / 1ps

// Congestion-window engine. Each req_ item is one event: mode selects send,
// acknowledgement or loss, and req_packet_number carries the acked or lost
// packet number. Every item yields exactly one rsp_ item holding the window
// end, congestion window, slow start threshold and phase after that event.
// An accepted item is held in the input register, applied to the window state
// when it advances, and its result is registered on rsp_ at that point.
// The state update is one short combinational pass, so one item is taken
// every cycle, back to back, while rsp_stall is low.
// The csr_ port writes the initial window (index 0), the initial threshold
// (index 1) and the NewReno variant bit (index 2); writing either initial
// value also loads the live window or threshold. Write only while idle.
// Reset clears both stages and returns the state to window 1, threshold
// 10000, slow start. While rsp_stall is high the result holds; one more item
// waits in the input register, after which req_stall rises.
module tcp_congestion_window_top #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_packet_number,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_window_end,
   output logic [15:0] rsp_window_size,
   output logic [15:0] rsp_threshold,
   output logic [1:0]  rsp_phase,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);
   import tcw_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   logic [1:0]             in_mode_ff;
   logic [COUNT_WIDTH-1:0] in_pn_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            rsp_end_ff, rsp_size_ff, rsp_thresh_ff;
   phase_type              rsp_phase_ff;
   logic                   accept;
   logic                   advance;
   csr_write_type          csr;
   logic [COUNT_WIDTH-1:0] window_end_in, window_size_in, threshold_in;
   phase_type              phase_in;

   assign advance      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign accept       = req_valid && !req_stall;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign csr.enable = csr_write_enable;
   assign csr.index  = csr_index;
   assign csr.data   = csr_write_data;

   tcw_engine #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .csr            (csr),
      .step           (advance),
      .mode           (in_mode_ff),
      .packet_number  (in_pn_ff),
      .window_end_in  (window_end_in),
      .window_size_in (window_size_in),
      .threshold_in   (threshold_in),
      .phase_in       (phase_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         in_mode_ff <= req_mode;
         in_pn_ff   <= COUNT_WIDTH'(req_packet_number);
      end
      if (advance) begin
         rsp_end_ff    <= 16'(window_end_in);
         rsp_size_ff   <= 16'(window_size_in);
         rsp_thresh_ff <= 16'(threshold_in);
         rsp_phase_ff  <= phase_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_window_end  = rsp_end_ff;
   assign rsp_window_size = rsp_size_ff;
   assign rsp_threshold   = rsp_thresh_ff;
   assign rsp_phase       = rsp_phase_ff;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a held item");

   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced item produced no result");

   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_end_ff)
         && $stable(rsp_size_ff) && $stable(rsp_thresh_ff) && $stable(rsp_phase_ff)))
      else $error("stalled result changed");

endmodule

@@ sim/tcp_congestion_window_top_tb.sv @@
`timescale 1ns / 1ps

module tcp_congestion_window_top_tb;
   import tcw_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int         HOLD_CYCLES = 48;

   typedef struct {
      logic [15:0] end_count;
      logic [15:0] size;
      logic [15:0] thr;
      phase_type   ph;
   } window_report_type;

   // Tracks the congestion state and queues the report each event should produce
   class window_scoreboard_type;
      logic [15:0]  init_window;
      logic [15:0]  init_threshold;
      logic         newreno;
      logic [15:0]  cwnd;
      logic [15:0]  ssthresh;
      logic [15:0]  win_start;
      logic [15:0]  win_end;
      phase_type    phase;
      logic [5:0]   drop_level;
      window_report_type expected_reports[$];
      int errors, checked, sends, fresh_acks, timeouts, losses, skipped_losses, unused;
      int settings;

      function new();
         init_window    = RESET_WINDOW;
         init_threshold = RESET_THRESHOLD;
         newreno        = 1'b0;
         cwnd           = RESET_WINDOW;
         ssthresh       = RESET_THRESHOLD;
         win_start      = 16'd0;
         win_end        = 16'd0;
         phase          = PH_SLOW;
         drop_level     = NO_LEVEL;
      endfunction

      function void write_reg(logic [1:0] index, logic [15:0] data);
         settings++;
         case (index)
            CSR_INITIAL_WINDOW: begin
               init_window = data;
               cwnd        = data;
            end
            CSR_INITIAL_THRESHOLD: begin
               init_threshold = data;
               ssthresh       = data;
            end
            CSR_VARIANT: newreno = data[0];
            default: ;
         endcase
      endfunction

      function logic [5:0] top_bit(logic [15:0] value);
         for (int b = 15; b > 0; b--) begin
            if (value[b]) return 6'(b);
         end
         return 6'd0;
      endfunction

      function void note_event(logic [1:0] mode, logic [15:0] number);
         window_report_type rep;
         logic [16:0]  doubled;
         logic [5:0]   level;
         case (mode)
            MODE_SEND: begin
               sends++;
               // in-flight is a signed difference: an end below the start always sends
               if (int'(win_end) - int'(win_start) < int'(cwnd) && win_end != 16'hFFFF)
                  win_end = win_end + 16'd1;
            end
            MODE_ACK: begin
               if (number > win_start) begin
                  fresh_acks++;
                  win_start = number;
                  if (phase == PH_AVOID) begin
                     if (cwnd != 16'hFFFF) cwnd = cwnd + 16'd1;
                  end else if (phase == PH_SLOW) begin
                     doubled = {cwnd, 1'b0};
                     cwnd    = doubled[16] ? 16'hFFFF : doubled[15:0];
                     if (cwnd >= ssthresh) begin
                        cwnd  = ssthresh;
                        phase = PH_AVOID;
                     end
                  end
               end else begin
                  // stale ack: treat as timeout
                  timeouts++;
                  if (win_end != 16'd0) win_end = win_end - 16'd1;
                  ssthresh = cwnd >> 1;
                  cwnd     = init_window;
                  phase    = PH_SLOW;
               end
            end
            MODE_LOSS: begin
               losses++;
               level = top_bit(number);
               phase = PH_RECOVER;
               if (newreno && level == drop_level) begin
                  skipped_losses++;
               end else begin
                  drop_level = level;
                  ssthresh   = cwnd >> 1;
                  cwnd       = ssthresh;
                  phase      = PH_AVOID;
               end
            end
            default: unused++;
         endcase
         rep.end_count = win_end;
         rep.size      = cwnd;
         rep.thr       = ssthresh;
         rep.ph        = phase;
         expected_reports.push_back(rep);
      endfunction

      function void compare(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [15:0] end_count, logic [15:0] size,
                                 logic [15:0] thr, logic [1:0] ph);
         window_report_type want;
         if (expected_reports.size() == 0) begin
            $error("result with no event outstanding: end %0d size %0d thr %0d phase %0d",
                   end_count, size, thr, ph);
            errors++;
            return;
         end
         want = expected_reports.pop_front();
         checked++;
         compare("window_end", want.end_count, end_count);
         compare("window_size", want.size, size);
         compare("threshold", want.thr, thr);
         compare("phase", 16'(want.ph), 16'(ph));
      endfunction

      function int outstanding();
         return expected_reports.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_mode;
   logic [15:0] req_packet_number;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_window_end;
   logic [15:0] rsp_window_size;
   logic [15:0] rsp_threshold;
   logic [1:0]  rsp_phase;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [15:0] csr_write_data;

   bit steady;
   bit hold_request;

   window_scoreboard_type sb = new();

   tcp_congestion_window_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_packet_number (req_packet_number),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_window_end    (rsp_window_end),
      .rsp_window_size   (rsp_window_size),
      .rsp_threshold     (rsp_threshold),
      .rsp_phase         (rsp_phase),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [15:0] fresh_number();
      int span;
      int number;
      span = (sb.win_end > sb.win_start) ? int'(sb.win_end - sb.win_start)
                                         : $urandom_range(1, 4);
      if (span > 32) span = 32;
      number = int'(sb.win_start) + $urandom_range(1, span);
      return (number > 65535) ? 16'hFFFF : 16'(number);
   endfunction

   // bias towards low levels so repeat losses under NewReno show up often
   function automatic logic [15:0] loss_number();
      int          k;
      logic [15:0] bits;
      if ($urandom_range(0, 19) == 0) return 16'd0;
      k    = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 15);
      bits = 16'($urandom);
      return (bits & ((16'd1 << k) - 16'd1)) | (16'd1 << k);
   endfunction

   // entered and left at a falling edge; valid stays high for a following item
   task automatic drive_event(logic [1:0] mode, logic [15:0] number);
      int gap;
      gap = steady ? 0 : gap_len();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_mode          = mode;
      req_packet_number = number;
      do @(posedge clock); while (req_stall);
      sb.note_event(mode, number);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [15:0] data);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      sb.write_reg(index, data);
   endtask

   task automatic random_event();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         drive_event(MODE_SEND, 16'($urandom));
      else if (pick < 72 && sb.win_start != 16'hFFFF)
         drive_event(MODE_ACK, fresh_number());
      else if (pick < 82)
         drive_event(MODE_ACK, 16'($urandom_range(0, sb.win_start)));
      else if (pick < 95)
         drive_event(MODE_LOSS, loss_number());
      else
         drive_event(MODE_UNUSED, 16'($urandom));
   endtask

   // receiver: random stall runs, plus a long hold-off on request
   initial begin
      int run_left;
      int gap;
      rsp_stall = 1'b0;
      run_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall    = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall = 1'b0;
            run_left  = 0;
         end else if (run_left > 0) begin
            run_left--;
         end else if (rsp_stall || steady) begin
            rsp_stall = 1'b0;
            run_left  = $urandom_range(0, 15);
         end else begin
            gap       = gap_len();
            rsp_stall = (gap != 0);
            run_left  = (gap != 0) ? gap - 1 : 0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         sb.check_result(rsp_window_end, rsp_window_size, rsp_threshold, rsp_phase);
   end

   initial begin
      #10_000_000;
      $display("tcp_congestion_window_top regression: fail");
      $finish;
   end

   initial begin
      logic [15:0] window_plan [7];
      logic [15:0] threshold_plan [7];
      logic        variant_plan [7];

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_mode          = MODE_SEND;
      req_packet_number = 16'd0;
      csr_write_enable  = 1'b0;
      csr_index         = CSR_INITIAL_WINDOW;
      csr_write_data    = 16'd0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset settings
      drive_event(MODE_SEND, 16'd0);
      drive_event(MODE_SEND, 16'hFFFF);      // window full: end holds
      drive_event(MODE_ACK, fresh_number()); // slow start doubles
      drive_event(MODE_ACK, 16'd0);          // timeout
      drive_event(MODE_ACK, 16'd0);          // timeout with end already at zero
      drive_event(MODE_UNUSED, 16'hFFFF);
      drive_event(MODE_LOSS, 16'd0);         // log of zero, window halves to zero
      drive_event(MODE_ACK, 16'd40);         // start jumps past the end
      drive_event(MODE_SEND, 16'h5A5A);      // end below start still sends
      drain();
      write_csr(CSR_INITIAL_WINDOW, 16'hFFFF);
      write_csr(CSR_VARIANT, 16'd1);
      drive_event(MODE_ACK, 16'd0);          // timeout reloads the full window
      drain();
      write_csr(CSR_INITIAL_THRESHOLD, 16'hFFFF);
      drive_event(MODE_ACK, fresh_number()); // doubling clamps at the top
      drive_event(MODE_ACK, fresh_number()); // avoidance increment saturates
      drive_event(MODE_LOSS, 16'hFFFF);
      drive_event(MODE_LOSS, 16'h8000);      // same level: skipped
      drive_event(MODE_ACK, fresh_number()); // fast recovery keeps the window
      drive_event(MODE_LOSS, 16'd1);
      drive_event(MODE_LOSS, 16'd0);         // zero shares level with one: skipped
      drain();
      write_csr(CSR_INITIAL_WINDOW, 16'd0);
      write_csr(CSR_INITIAL_THRESHOLD, 16'd0);
      write_csr(CSR_VARIANT, 16'd0);
      drive_event(MODE_ACK, 16'd0);
      drive_event(MODE_ACK, fresh_number());
      drive_event(MODE_LOSS, 16'd2);
      drive_event(MODE_LOSS, 16'd3);         // Reno takes the repeat

      window_plan    = '{RESET_WINDOW, 16'd0, 16'hFFFF, 16'd2, 16'($urandom), 16'd1,
                         16'($urandom_range(0, 64))};
      threshold_plan = '{RESET_THRESHOLD, 16'd0, 16'hFFFF, 16'd8, 16'($urandom),
                         16'hFFFF, 16'($urandom_range(0, 512))};
      variant_plan   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'($urandom)};

      for (int p = 0; p < 7; p++) begin
         drain();
         write_csr(CSR_INITIAL_WINDOW, window_plan[p]);
         write_csr(CSR_INITIAL_THRESHOLD, threshold_plan[p]);
         write_csr(CSR_VARIANT, {15'd0, variant_plan[p]});
         steady = (p % 3 == 1);
         for (int i = 0; i < 250; i++) begin
            if (p == 3 && i == 120) begin
               // back up the pipe, then pause until every result is in
               hold_request = 1'b1;
               steady       = 1'b1;
               repeat (24) random_event();
               drain();
               steady = 1'b0;
            end
            random_event();
         end
      end

      drain();
      repeat (4) @(posedge clock);

      $display("Checked %0d results across %0d register writes: %0d sends, %0d fresh acks,",
               sb.checked, sb.settings, sb.sends, sb.fresh_acks);
      $display("%0d timeouts, %0d losses (%0d skipped as repeats), %0d unused events.",
               sb.timeouts, sb.losses, sb.skipped_losses, sb.unused);
      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("tcp_congestion_window_top regression: pass");
      else
         $display("tcp_congestion_window_top regression: fail");
      $finish;
   end

endmodule

@@ tcp_congestion_window_top.f @@
sv/tcw_pkg.sv
sv/tcw_engine.sv
sv/tcp_congestion_window_top.sv
sim/tcp_congestion_window_top_tb.sv
